### hdl/ihv_pkg.sv
// shared types and constants for the ipv4 header validator
// used by every module of the block; no dependencies
`timescale 1ns / 1ps

package ihv_pkg;

  localparam int COUNT_W = 17;
  localparam int BYTE_W  = 8;
  localparam int SUM_W   = 16;
  localparam int TLEN_W  = 16;
  localparam int FRAG_W  = 13;
  localparam int ADDR_W  = 32;
  localparam int HDR_W   = 6;
  localparam int L4_W    = 11;
  localparam int ERR_W   = 4;

  localparam int QDEPTH = 2;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  localparam logic [COUNT_W-1:0] COUNT_MAX    = '1;
  localparam logic [COUNT_W-1:0] MIN_HDR      = COUNT_W'(20);
  localparam logic [BYTE_W-1:0]  PROTO_AH     = 8'd51;
  localparam logic [3:0]         IP_VERSION   = 4'd4;
  localparam logic [SUM_W-1:0]   SUM_GOOD     = 16'hFFFF;
  localparam logic [BYTE_W-1:0]  LOOPBACK_NET = 8'd127;

  typedef enum logic [ERR_W-1:0] {
    ERR_OK        = 4'd0,
    ERR_SHORT     = 4'd1,
    ERR_VERSION   = 4'd2,
    ERR_IHL       = 4'd3,
    ERR_CHECKSUM  = 4'd4,
    ERR_TINY_FRAG = 4'd5,
    ERR_OVERSIZE  = 4'd6,
    ERR_TRUNCATED = 4'd7,
    ERR_BAD_SRC   = 4'd8,
    ERR_LOOP_DST  = 4'd9,
    ERR_SAME_ADDR = 4'd10,
    ERR_SHORT_AH  = 4'd11
  } err_code_e;

  // everything the verdict needs, captured by the end of a packet
  typedef struct packed {
    logic [COUNT_W-1:0] len;
    logic [BYTE_W-1:0]  ver_ihl;
    logic [SUM_W-1:0]   sum;
    logic [TLEN_W-1:0]  total_len;
    logic [FRAG_W-1:0]  frag_units;
    logic [BYTE_W-1:0]  proto;
    logic [ADDR_W-1:0]  src_addr;
    logic [ADDR_W-1:0]  dst_addr;
    logic [BYTE_W-1:0]  ah_next;
    logic [BYTE_W-1:0]  ah_len;
  } hdr_rec_t;

endpackage

### hdl/ihv_front.sv
// byte front end: counts bytes, sums header words, captures header fields
// pushes one record per packet into the queue; depends on ihv_pkg
`timescale 1ns / 1ps

module ihv_front import ihv_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [BYTE_W-1:0] data_byte_i,
  input  logic              last_byte_i,
  output logic              push_o,
  output hdr_rec_t          rec_o,
  input  logic              q_ready_i
);

  logic [COUNT_W-1:0] count_q, count_d, count_upd;
  logic [SUM_W-1:0]   sum_q, sum_d, sum_upd;
  logic [BYTE_W-1:0]  hold_q, hold_d, hold_upd;
  logic [BYTE_W-1:0]  vib_q, vib_d, vib_upd;
  logic [TLEN_W-1:0]  tlen_q, tlen_d, tlen_upd;
  logic [FRAG_W-1:0]  frag_q, frag_d, frag_upd;
  logic [BYTE_W-1:0]  proto_q, proto_d, proto_upd;
  logic [ADDR_W-1:0]  sa_q, sa_d, sa_upd;
  logic [ADDR_W-1:0]  da_q, da_d, da_upd;
  logic [BYTE_W-1:0]  ahnh_q, ahnh_d, ahnh_upd;
  logic [BYTE_W-1:0]  ahlen_q, ahlen_d, ahlen_upd;

  logic               xfer;
  logic [BYTE_W-1:0]  vib_now;
  logic [HDR_W-1:0]   hdr_len;
  logic [HDR_W:0]     hdr_len_p1;
  logic [SUM_W:0]     word_sum;

  assign in_ready_o = q_ready_i;
  assign xfer       = in_valid_i && in_ready_o;
  assign push_o     = xfer && last_byte_i;

  // ihl is taken from the live byte when this is the first one
  assign vib_now    = (count_q == '0) ? data_byte_i : vib_q;
  assign hdr_len    = {vib_now[3:0], 2'b00};
  assign hdr_len_p1 = {1'b0, hdr_len} + (HDR_W+1)'(1);
  assign word_sum   = {1'b0, sum_q} + {1'b0, hold_q, data_byte_i};

  always_comb begin
    count_upd = count_q;
    sum_upd   = sum_q;
    hold_upd  = hold_q;
    vib_upd   = vib_q;
    tlen_upd  = tlen_q;
    frag_upd  = frag_q;
    proto_upd = proto_q;
    sa_upd    = sa_q;
    da_upd    = da_q;
    ahnh_upd  = ahnh_q;
    ahlen_upd = ahlen_q;
    if (xfer) begin
      unique case (count_q)
        COUNT_W'(0): vib_upd = data_byte_i;
        COUNT_W'(2): tlen_upd = {data_byte_i, tlen_q[7:0]};
        COUNT_W'(3): tlen_upd = {tlen_q[15:8], data_byte_i};
        COUNT_W'(6): frag_upd = {data_byte_i[4:0], frag_q[7:0]};
        COUNT_W'(7): frag_upd = {frag_q[12:8], data_byte_i};
        COUNT_W'(9): proto_upd = data_byte_i;
        COUNT_W'(12), COUNT_W'(13), COUNT_W'(14), COUNT_W'(15):
          sa_upd = {sa_q[ADDR_W-BYTE_W-1:0], data_byte_i};
        COUNT_W'(16), COUNT_W'(17), COUNT_W'(18), COUNT_W'(19):
          da_upd = {da_q[ADDR_W-BYTE_W-1:0], data_byte_i};
        default: ;
      endcase
      // first two bytes right after the ip header, used when it is an ah
      if (count_q == COUNT_W'(hdr_len)) ahnh_upd = data_byte_i;
      if (count_q == COUNT_W'(hdr_len_p1)) ahlen_upd = data_byte_i;
      if (count_q < COUNT_W'(hdr_len)) begin
        if (!count_q[0]) begin
          hold_upd = data_byte_i;
        end else begin
          sum_upd = word_sum[SUM_W-1:0] + SUM_W'(word_sum[SUM_W]);
        end
      end
      if (count_q != COUNT_MAX) count_upd = count_q + COUNT_W'(1);
    end
  end

  always_comb begin
    rec_o.len        = count_upd;
    rec_o.ver_ihl    = vib_upd;
    rec_o.sum        = sum_upd;
    rec_o.total_len  = tlen_upd;
    rec_o.frag_units = frag_upd;
    rec_o.proto      = proto_upd;
    rec_o.src_addr   = sa_upd;
    rec_o.dst_addr   = da_upd;
    rec_o.ah_next    = ahnh_upd;
    rec_o.ah_len     = ahlen_upd;
  end

  // packet end clears everything for the next packet
  always_comb begin
    if (push_o) begin
      count_d = '0;
      sum_d   = '0;
      hold_d  = '0;
      vib_d   = '0;
      tlen_d  = '0;
      frag_d  = '0;
      proto_d = '0;
      sa_d    = '0;
      da_d    = '0;
      ahnh_d  = '0;
      ahlen_d = '0;
    end else begin
      count_d = count_upd;
      sum_d   = sum_upd;
      hold_d  = hold_upd;
      vib_d   = vib_upd;
      tlen_d  = tlen_upd;
      frag_d  = frag_upd;
      proto_d = proto_upd;
      sa_d    = sa_upd;
      da_d    = da_upd;
      ahnh_d  = ahnh_upd;
      ahlen_d = ahlen_upd;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      sum_q   <= '0;
      hold_q  <= '0;
      vib_q   <= '0;
      tlen_q  <= '0;
      frag_q  <= '0;
      proto_q <= '0;
      sa_q    <= '0;
      da_q    <= '0;
      ahnh_q  <= '0;
      ahlen_q <= '0;
    end else begin
      count_q <= count_d;
      sum_q   <= sum_d;
      hold_q  <= hold_d;
      vib_q   <= vib_d;
      tlen_q  <= tlen_d;
      frag_q  <= frag_d;
      proto_q <= proto_d;
      sa_q    <= sa_d;
      da_q    <= da_d;
      ahnh_q  <= ahnh_d;
      ahlen_q <= ahlen_d;
    end
  end

`ifndef SYNTHESIS
  a_clear_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_o |=> (count_q == '0) && (sum_q == '0) && (vib_q == '0))
    else $error("front state not cleared after last byte");

  a_idle_state_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q == '0) |-> (sum_q == '0) && (hold_q == '0) && (sa_q == '0) && (ahnh_q == '0))
    else $error("captured state nonzero before first byte");

  a_count_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (xfer && !last_byte_i && (count_q != COUNT_MAX)) |=> (count_q == $past(count_q) + 1'b1))
    else $error("byte count did not advance");
`endif

endmodule

### hdl/ihv_queue.sv
// short record queue between the byte front end and the verdict stage
// register based, QDEPTH entries; depends on ihv_pkg
`timescale 1ns / 1ps

module ihv_queue import ihv_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     push_i,
  input  hdr_rec_t push_rec_i,
  output logic     push_ready_o,
  output logic     pop_valid_o,
  output hdr_rec_t pop_rec_o,
  input  logic     pop_ready_i
);

  hdr_rec_t           mem_q [QDEPTH];
  logic [QPTR_W-1:0]  wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0]  rd_ptr_q, rd_ptr_d;
  logic [QCNT_W-1:0]  count_q, count_d;
  logic               do_push, do_pop;

  assign push_ready_o = (count_q != QCNT_W'(QDEPTH));
  assign pop_valid_o  = (count_q != '0);
  assign pop_rec_o    = mem_q[rd_ptr_q];
  assign do_push      = push_i && push_ready_o;
  assign do_pop       = pop_valid_o && pop_ready_i;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_q + QPTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_q + QPTR_W'(1);
    end
    if (do_push && !do_pop) count_d = count_q + QCNT_W'(1);
    if (!do_push && do_pop) count_d = count_q - QCNT_W'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_ptr_q] <= push_rec_i;
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= QCNT_W'(QDEPTH))
    else $error("queue count beyond depth");

  a_push_only_when_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> push_ready_o)
    else $error("record pushed into full queue");

  a_count_tracks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    1'b1 |=> (count_q == $past(count_q) + QCNT_W'($past(do_push)) - QCNT_W'($past(do_pop))))
    else $error("queue count out of step with transfers");
`endif

endmodule

### hdl/ihv_judge.sv
// verdict stage: runs the ordered checks on one packet record
// and holds the result in an output register; depends on ihv_pkg
`timescale 1ns / 1ps

module ihv_judge import ihv_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              rec_valid_i,
  input  hdr_rec_t          rec_i,
  output logic              rec_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [ERR_W-1:0]  error_code_o,
  output logic [BYTE_W-1:0] upper_protocol_o,
  output logic [L4_W-1:0]   l4_offset_o
);

  logic               valid_q;
  err_code_e          err_q, err_d;
  logic [BYTE_W-1:0]  proto_q, proto_d;
  logic [L4_W-1:0]    l4_q, l4_d;

  logic [HDR_W-1:0]   hdr_len;
  logic [TLEN_W-1:0]  frag_bytes;
  logic [TLEN_W:0]    end_off;
  logic [COUNT_W-1:0] ah_end;
  logic [BYTE_W:0]    ah_words;
  logic               load;

  assign load        = rec_valid_i && (!valid_q || out_ready_i);
  assign rec_ready_o = !valid_q || out_ready_i;

  assign hdr_len    = {rec_i.ver_ihl[3:0], 2'b00};
  assign frag_bytes = {rec_i.frag_units, 3'b000};
  assign end_off    = {1'b0, frag_bytes} + {1'b0, rec_i.total_len};
  assign ah_end     = COUNT_W'(hdr_len) + COUNT_W'(8);
  assign ah_words   = {1'b0, rec_i.ah_len} + (BYTE_W+1)'(2);

  always_comb begin
    err_d   = ERR_OK;
    proto_d = '0;
    l4_d    = '0;
    priority if (rec_i.len < MIN_HDR) begin
      err_d = ERR_SHORT;
    end else if (rec_i.ver_ihl[7:4] != IP_VERSION) begin
      err_d = ERR_VERSION;
    end else if (COUNT_W'(hdr_len) < MIN_HDR) begin
      err_d = ERR_IHL;
    end else if (rec_i.len < COUNT_W'(hdr_len)) begin
      err_d = ERR_SHORT;
    end else if (rec_i.sum != SUM_GOOD) begin
      err_d = ERR_CHECKSUM;
    end else if ((frag_bytes != '0) && (COUNT_W'(rec_i.total_len) == MIN_HDR)) begin
      err_d = ERR_TINY_FRAG;
    end else if (end_off[TLEN_W]) begin
      err_d = ERR_OVERSIZE;
    end else if (COUNT_W'(rec_i.total_len) > rec_i.len) begin
      err_d = ERR_TRUNCATED;
    end else if ((rec_i.src_addr[31:29] == 3'b111) ||
                 (rec_i.src_addr[31:24] == LOOPBACK_NET) ||
                 (rec_i.src_addr == '1)) begin
      // class d/e, loopback, limited broadcast
      err_d = ERR_BAD_SRC;
    end else if (rec_i.dst_addr[31:24] == LOOPBACK_NET) begin
      err_d = ERR_LOOP_DST;
    end else if (rec_i.src_addr == rec_i.dst_addr) begin
      err_d = ERR_SAME_ADDR;
    end else if (rec_i.proto == PROTO_AH) begin
      if (ah_end > rec_i.len) begin
        err_d = ERR_SHORT_AH;
      end else begin
        proto_d = rec_i.ah_next;
        l4_d    = L4_W'(hdr_len) + {ah_words, 2'b00};
      end
    end else begin
      proto_d = rec_i.proto;
      l4_d    = L4_W'(hdr_len);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load) begin
      valid_q <= 1'b1;
    end else if (out_ready_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      err_q   <= err_d;
      proto_q <= proto_d;
      l4_q    <= l4_d;
    end
  end

  assign out_valid_o      = valid_q;
  assign error_code_o     = err_q;
  assign upper_protocol_o = proto_q;
  assign l4_offset_o      = l4_q;

endmodule

### hdl/ipv4_header_validator.sv
// The last byte's record passes through the record queue, then the verdict register.
// Throughput: one byte per cycle, back to back, across packet boundaries;
// the byte front end stalls only when the two-record queue is full.
// Reset: asynchronous, active low; clears byte count, checksum, captured
// fields, queue pointers and output valid. No clearing pass is needed.
// top level: front end, record queue and verdict stage; depends on ihv_pkg
`timescale 1ns / 1ps

module ipv4_header_validator import ihv_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [BYTE_W-1:0] data_byte_i,
  input  logic              last_byte_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [ERR_W-1:0]  error_code_o,
  output logic [BYTE_W-1:0] upper_protocol_o,
  output logic [L4_W-1:0]   l4_offset_o
);

  logic     push, push_ready;
  hdr_rec_t push_rec;
  logic     pop_valid, pop_ready;
  hdr_rec_t pop_rec;

  ihv_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .data_byte_i (data_byte_i),
    .last_byte_i (last_byte_i),
    .push_o      (push),
    .rec_o       (push_rec),
    .q_ready_i   (push_ready)
  );

  ihv_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_rec_i   (push_rec),
    .push_ready_o (push_ready),
    .pop_valid_o  (pop_valid),
    .pop_rec_o    (pop_rec),
    .pop_ready_i  (pop_ready)
  );

  ihv_judge u_judge (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .rec_valid_i      (pop_valid),
    .rec_i            (pop_rec),
    .rec_ready_o      (pop_ready),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .error_code_o     (error_code_o),
    .upper_protocol_o (upper_protocol_o),
    .l4_offset_o      (l4_offset_o)
  );

endmodule
